// ===== sv/tsr_pkg.sv =====
// Shared types and constants for the triangle span rasterizer.
// No dependencies; imported by tsr_edge_walk and triangle_span_rasterizer.
package tsr_pkg;

    localparam int COORD_W       = 6;   // vertex and span coordinate width
    localparam int DEF_TILE_ROWS = 64;  // default tile height in rows
    localparam int ERR_W         = 9;   // Bresenham error term, signed

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [ERR_W-1:0] t_err;

    // Current pixel of an edge walk and whether it is the final one
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_walk_pix;

    // One row of the span store
    typedef struct packed {
        t_coord left;
        t_coord right;
    } t_span;

    // Edge being walked
    typedef enum logic [1:0] {
        EDGE_AB = 2'd0,
        EDGE_BC = 2'd1,
        EDGE_CA = 2'd2
    } t_edge;

endpackage

// ===== sv/tsr_edge_walk.sv =====
// Bresenham edge stepper: loads two endpoints and steps one pixel per request.
// Depends on tsr_pkg.
module tsr_edge_walk
    import tsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  logic      i_step,
    input  t_coord    i_x0,
    input  t_coord    i_y0,
    input  t_coord    i_x1,
    input  t_coord    i_y1,
    output t_walk_pix o_pix
);

    t_coord adx;
    t_coord ady;
    logic   horiz;
    logic   swap;
    t_coord sx0;
    t_coord sy0;
    t_coord sx1;
    t_coord sy1;
    t_coord major;
    t_coord minor;
    logic   minor_neg;
    t_err   p_init;

    t_coord r_x;
    t_coord r_y;
    t_coord r_cnt;
    t_err   r_p;
    t_err   r_inc_step;
    t_err   r_inc_hold;
    logic   r_horiz;
    logic   r_neg;

    t_coord n_minor;

    // Orient the edge: lowest major coordinate first
    always_comb begin
        adx   = (i_x0 > i_x1) ? i_x0 - i_x1 : i_x1 - i_x0;
        ady   = (i_y0 > i_y1) ? i_y0 - i_y1 : i_y1 - i_y0;
        horiz = adx > ady;
        swap  = horiz ? (i_x0 > i_x1) : (i_y0 > i_y1);
        sx0   = swap ? i_x1 : i_x0;
        sy0   = swap ? i_y1 : i_y0;
        sx1   = swap ? i_x0 : i_x1;
        sy1   = swap ? i_y0 : i_y1;
        major = horiz ? sx1 - sx0 : sy1 - sy0;
        minor = horiz ? ady : adx;
        minor_neg = horiz ? (sy1 < sy0) : (sx1 < sx0);
        p_init = t_err'({minor, 1'b0}) - t_err'(major);
    end

    always_comb begin
        if (r_horiz) begin
            n_minor = r_neg ? r_y - 1'b1 : r_y + 1'b1;
        end else begin
            n_minor = r_neg ? r_x - 1'b1 : r_x + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x        <= sx0;
            r_y        <= sy0;
            r_cnt      <= major;
            r_p        <= p_init;
            r_inc_hold <= t_err'({minor, 1'b0});
            r_inc_step <= t_err'({minor, 1'b0}) - t_err'({major, 1'b0});
            r_horiz    <= horiz;
            r_neg      <= minor_neg;
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
            // advance the major axis; move the minor axis when the error allows
            if (r_horiz) begin
                r_x <= r_x + 1'b1;
                if (!r_p[ERR_W-1]) begin
                    r_y <= n_minor;
                end
            end else begin
                r_y <= r_y + 1'b1;
                if (!r_p[ERR_W-1]) begin
                    r_x <= n_minor;
                end
            end
            r_p <= r_p + (r_p[ERR_W-1] ? r_inc_hold : r_inc_step);
        end
    end

    assign o_pix.x    = r_x;
    assign o_pix.y    = r_y;
    assign o_pix.last = (r_cnt == '0);

endmodule

// ===== sv/triangle_span_rasterizer.sv =====
// Top level of the triangle span rasterizer: sequencer, span store, output register.
// Depends on tsr_pkg and tsr_edge_walk.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------
//  triangle | in        | i_valid, o_stall | i_ax i_ay i_bx i_by i_cx i_cy
//  span     | out       | o_valid, i_stall | o_row o_left_x o_right_x o_last
//
// One triangle at a time. Each edge has a setup state, then each pixel is read and
// then updated in the span store (a row memory with one write port and one
// registered read port). The row scan then visits each row up to the bottom row,
// fetching and emitting each stored span; a span waits in emit under i_stall.
// o_stall is high from the transfer of a triangle until its last span is taken,
// or until the walk ends if no pixel of the triangle fell inside the tile.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending span; the row valid bits are cleared at the start of every triangle.
module triangle_span_rasterizer
    import tsr_pkg::*;
#(
    parameter int TILE_ROWS = DEF_TILE_ROWS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by,
    input  t_coord i_cx,
    input  t_coord i_cy,
    output logic   o_valid,
    input  logic   i_stall,
    output t_coord o_row,
    output t_coord o_left_x,
    output t_coord o_right_x,
    output logic   o_last
);

    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // Control registers
    t_state               r_state;
    t_state               n_state;
    t_edge                r_edge;
    t_edge                n_edge;
    t_row                 r_row;
    t_row                 n_row;
    t_row                 r_max_row;
    t_row                 n_max_row;
    logic                 r_any;
    logic                 n_any;
    logic [TILE_ROWS-1:0] r_valid;
    logic [TILE_ROWS-1:0] n_valid;
    logic                 r_out_valid;
    logic                 n_out_valid;

    // Payload registers
    t_coord r_vx [3];
    t_coord r_vy [3];
    t_span  r_rd;
    t_coord r_out_row;
    t_coord r_out_left;
    t_coord r_out_right;
    logic   r_out_last;

    // Span store
    t_span  mem [TILE_ROWS];
    logic   rd_en;
    t_row   rd_addr;
    logic   wr_en;
    t_span  wr_data;

    // Edge walker hookup
    t_coord    e_x0;
    t_coord    e_y0;
    t_coord    e_x1;
    t_coord    e_y1;
    logic      edge_empty;
    logic      walk_load;
    logic      walk_step;
    t_walk_pix pix;
    t_row      pix_row;
    logic      in_tile;
    logic      next_edge;
    logic      accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Select the endpoints of the edge in hand
    always_comb begin
        unique case (r_edge)
            EDGE_AB: begin
                e_x0 = r_vx[0]; e_y0 = r_vy[0]; e_x1 = r_vx[1]; e_y1 = r_vy[1];
            end
            EDGE_BC: begin
                e_x0 = r_vx[1]; e_y0 = r_vy[1]; e_x1 = r_vx[2]; e_y1 = r_vy[2];
            end
            EDGE_CA: begin
                e_x0 = r_vx[2]; e_y0 = r_vy[2]; e_x1 = r_vx[0]; e_y1 = r_vy[0];
            end
            default: begin
                e_x0 = r_vx[0]; e_y0 = r_vy[0]; e_x1 = r_vx[1]; e_y1 = r_vy[1];
            end
        endcase
    end

    // A zero-length edge touches nothing
    assign edge_empty = (e_x0 == e_x1) && (e_y0 == e_y1);

    tsr_edge_walk u_walk (
        .i_clk  (i_clk),
        .i_load (walk_load),
        .i_step (walk_step),
        .i_x0   (e_x0),
        .i_y0   (e_y0),
        .i_x1   (e_x1),
        .i_y1   (e_y1),
        .o_pix  (pix)
    );

    // Pixels on rows past the tile are dropped
    assign in_tile = (7'(pix.y) < 7'(TILE_ROWS));
    assign pix_row = pix.y[ROW_W-1:0];

    // Widen the stored span of the pixel's row, or open it if the row is new
    always_comb begin
        if (r_valid[pix_row]) begin
            wr_data.left  = (r_rd.left < pix.x)  ? r_rd.left  : pix.x;
            wr_data.right = (r_rd.right > pix.x) ? r_rd.right : pix.x;
        end else begin
            wr_data.left  = pix.x;
            wr_data.right = pix.x;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_edge      = r_edge;
        n_row       = r_row;
        n_max_row   = r_max_row;
        n_any       = r_any;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        walk_load   = 1'b0;
        walk_step   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_row;
        wr_en       = 1'b0;
        next_edge   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                    n_edge  = EDGE_AB;
                    n_valid = '0;
                    n_any   = 1'b0;
                end
            end
            S_LOAD: begin
                walk_load = 1'b1;
                if (edge_empty) begin
                    next_edge = 1'b1;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                rd_en   = in_tile;
                rd_addr = pix_row;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (in_tile) begin
                    wr_en            = 1'b1;
                    n_valid[pix_row] = 1'b1;
                    n_any            = 1'b1;
                    if (!r_any || (pix_row > r_max_row)) begin
                        n_max_row = pix_row;
                    end
                end
                if (pix.last) begin
                    next_edge = 1'b1;
                end else begin
                    walk_step = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_SCAN: begin
                if (r_valid[r_row]) begin
                    rd_en   = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_FETCH: begin
                n_out_valid = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // hold the span until the transfer completes
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the following edge, or start the row scan after the third
        if (next_edge) begin
            if (r_edge == EDGE_CA) begin
                n_row   = '0;
                n_state = n_any ? S_SCAN : S_IDLE;
            end else begin
                n_edge  = t_edge'(r_edge + 2'd1);
                n_state = S_LOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_edge      <= EDGE_AB;
            r_row       <= '0;
            r_max_row   <= '0;
            r_any       <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_edge      <= n_edge;
            r_row       <= n_row;
            r_max_row   <= n_max_row;
            r_any       <= n_any;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the triangle on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vx[0] <= i_ax;
            r_vy[0] <= i_ay;
            r_vx[1] <= i_bx;
            r_vy[1] <= i_by;
            r_vx[2] <= i_cx;
            r_vy[2] <= i_cy;
        end
    end

    // Span store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[pix_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Output register, loaded from the registered row read in the fetch state
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_out_row   <= COORD_W'(r_row);
            r_out_left  <= r_rd.left;
            r_out_right <= r_rd.right;
            r_out_last  <= (r_row == r_max_row);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_row     = r_out_row;
    assign o_left_x  = r_out_left;
    assign o_right_x = r_out_right;
    assign o_last    = r_out_last;

    // A span is only offered from the emit state
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_EMIT))
        else $error("span offered outside emit state");

    // No new triangle is taken while a span is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !r_out_valid)
        else $error("input open while a span is pending");

    // Every triangle starts with an empty span store
    a_clear_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_valid == '0) && (r_state == S_LOAD))
        else $error("row valid bits not cleared on triangle transfer");

    // The last span of a triangle returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (r_state == S_IDLE))
        else $error("block not idle after final span");

endmodule
